### hdl/block_buffer_cache_allocator_assert.svh
// Assertion shorthands for the buffer cache allocator.
`ifndef BLOCK_BUFFER_CACHE_ALLOCATOR_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define BBCA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("bbca: same-cycle check failed");

// Next-cycle implication.
`define BBCA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("bbca: next-cycle check failed");

`endif

### hdl/bbca_pkg.sv
package bbca_pkg;

	localparam int NUM_ENTRIES = 256;
	localparam int IDX_W       = $clog2(NUM_ENTRIES);
	localparam int SCAN_W      = IDX_W + 1;
	localparam int ENTRY_W     = 8;
	localparam int DEV_W       = 16;
	localparam int BLK_W       = 32;
	localparam int CNT_W       = 8;

	typedef enum logic [1:0] {
		K_GET  = 2'd0,
		K_REL  = 2'd1,
		K_MARK = 2'd2,
		K_INV  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		STS_HIT     = 4'd0,
		STS_ALLOC   = 4'd1,
		STS_NONE    = 4'd2,
		STS_LOCKED  = 4'd3,
		STS_DIRTY   = 4'd4,
		STS_REL     = 4'd5,
		STS_RELERR  = 4'd6,
		STS_MARKS   = 4'd7,
		STS_INVAL   = 4'd8
	} status_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_HSCAN,
		S_RSCAN,
		S_DECIDE,
		S_MV1,
		S_MV2,
		S_MV3,
		S_MV4,
		S_UPD,
		S_INV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [DEV_W-1:0] dev;
		logic [BLK_W-1:0] blk;
		logic [CNT_W-1:0] cnt;
		logic             dirty;
		logic             lock;
		logic             valid;
	} ent_t;

	typedef struct packed {
		logic             next_we;
		logic [IDX_W-1:0] next_addr;
		logic [IDX_W-1:0] next_data;
		logic             prev_we;
		logic [IDX_W-1:0] prev_addr;
		logic [IDX_W-1:0] prev_data;
	} ring_wr_t;

endpackage

### hdl/bbca_ent.sv
module bbca_ent (
	input  logic                      clk,
	input  logic [bbca_pkg::IDX_W-1:0] raddr,
	output bbca_pkg::ent_t            rdata,
	input  logic                      we,
	input  logic [bbca_pkg::IDX_W-1:0] waddr,
	input  bbca_pkg::ent_t            wdata
);
	import bbca_pkg::*;

	ent_t mem [NUM_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/bbca_ring.sv
module bbca_ring (
	input  logic                       clk,
	input  logic [bbca_pkg::IDX_W-1:0] raddr,
	output logic [bbca_pkg::IDX_W-1:0] rnext,
	output logic [bbca_pkg::IDX_W-1:0] rprev,
	input  bbca_pkg::ring_wr_t         wr
);
	import bbca_pkg::*;

	logic [IDX_W-1:0] next_mem [NUM_ENTRIES];
	logic [IDX_W-1:0] prev_mem [NUM_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.next_we) begin
			next_mem[wr.next_addr] <= wr.next_data;
		end
		rnext <= next_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.prev_we) begin
			prev_mem[wr.prev_addr] <= wr.prev_data;
		end
		rprev <= prev_mem[raddr];
	end

endmodule

### hdl/block_buffer_cache_allocator.sv
// channel  dir  tdata (low bit up)                                  tuser
// s_*      in   device, block_number, entry_index, lock, dirty,     kind
//               valid, zero fill to 64
// m_*      out  result_entry, entry_locked, entry_valid,            status
//               writeback_device, zero fill to 32
//
// After reset a clearing pass over all NUM_ENTRIES entries loads the table and ring; no word taken.
// Release and mark update read the addressed entry and may update it; invalidate scans every
// entry; a get with a nonzero device first scans the table for a hit. A get miss, or any get
// for device 0, walks the ring from its head, then decides and, on an allocation, relinks the
// victim just before the head. One entry per cycle through the entry table read port.
// One word in flight; the done state holds while a previous result still waits for m_tready.
module block_buffer_cache_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // device, block_number, entry_index, lock, dirty, valid
	input  logic [1:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // result_entry, entry_locked, entry_valid, writeback_device
	output logic [3:0]  m_tuser    // status
);
	import bbca_pkg::*;

	state_t                state_q, state_d;
	logic [SCAN_W-1:0]     cnt_q, cnt_d;
	logic                  vld_q, vld_d;
	logic [IDX_W-1:0]      cur_q, cur_d;
	kind_t                 kind_q, kind_d;
	logic [DEV_W-1:0]      dev_q, dev_d;
	logic [BLK_W-1:0]      blk_q, blk_d;
	logic [ENTRY_W-1:0]    eidx_q, eidx_d;
	logic                  found_q, found_d;
	logic [IDX_W-1:0]      best_q, best_d;
	logic [1:0]            bbad_q, bbad_d;
	ent_t                  bent_q, bent_d;
	logic [IDX_W-1:0]      head_q, head_d;
	logic [IDX_W-1:0]      t_q, t_d;
	status_t               rsts_q, rsts_d;
	logic [ENTRY_W-1:0]    rent_q, rent_d;
	logic                  rlk_q, rlk_d, rvd_q, rvd_d;
	logic [DEV_W-1:0]      rwb_q, rwb_d;

	// new marks for a mark update, held from the accepted word
	logic                  set_lock_q, set_dirty_q, set_valid_q;

	logic                  m_tvalid_q;
	logic [31:0]           m_tdata_q;
	logic [3:0]            m_tuser_q;
	logic                  out_load;

	logic [IDX_W-1:0]      ent_raddr, ent_waddr;
	ent_t                  ent_rdata, ent_wdata;
	logic                  ent_we;
	logic [IDX_W-1:0]      ring_raddr, ring_rnext, ring_rprev;
	ring_wr_t              ring_wr;

	logic [1:0]            bad;
	logic                  take;
	logic                  in_range;
	logic [IDX_W-1:0]      cnt_idx;

	bbca_ent u_ent (
		.clk   (clk),
		.raddr (ent_raddr),
		.rdata (ent_rdata),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata)
	);

	bbca_ring u_ring (
		.clk   (clk),
		.raddr (ring_raddr),
		.rnext (ring_rnext),
		.rprev (ring_rprev),
		.wr    (ring_wr)
	);

	assign s_tready = (state_q == S_IDLE);
	assign cnt_idx  = cnt_q[IDX_W-1:0];
	assign bad      = {ent_rdata.dirty, ent_rdata.lock};
	assign take     = (ent_rdata.cnt == '0) && (!found_q || (bad < bbad_q));
	assign in_range = (32'(eidx_q) < 32'(NUM_ENTRIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_q   <= '0;
			vld_q   <= 1'b0;
			found_q <= 1'b0;
			head_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			vld_q   <= vld_d;
			found_q <= found_d;
			head_q  <= head_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		kind_q <= kind_d;
		dev_q  <= dev_d;
		blk_q  <= blk_d;
		eidx_q <= eidx_d;
		best_q <= best_d;
		bbad_q <= bbad_d;
		bent_q <= bent_d;
		t_q    <= t_d;
		rsts_q <= rsts_d;
		rent_q <= rent_d;
		rlk_q  <= rlk_d;
		rvd_q  <= rvd_d;
		rwb_q  <= rwb_d;
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		vld_d     = vld_q;
		cur_d     = cur_q;
		kind_d    = kind_q;
		dev_d     = dev_q;
		blk_d     = blk_q;
		eidx_d    = eidx_q;
		found_d   = found_q;
		best_d    = best_q;
		bbad_d    = bbad_q;
		bent_d    = bent_q;
		head_d    = head_q;
		t_d       = t_q;
		rsts_d    = rsts_q;
		rent_d    = rent_q;
		rlk_d     = rlk_q;
		rvd_d     = rvd_q;
		rwb_d     = rwb_q;
		ent_raddr = cur_q;
		ent_we    = 1'b0;
		ent_waddr = cur_q;
		ent_wdata = ent_rdata;
		ring_raddr = best_q;
		ring_wr   = '0;
		out_load  = 1'b0;

		unique case (state_q)
			S_CLR: begin
				ent_we            = 1'b1;
				ent_waddr         = cnt_idx;
				ent_wdata         = '0;
				ring_wr.next_we   = 1'b1;
				ring_wr.next_addr = cnt_idx;
				ring_wr.next_data = (cnt_idx == IDX_W'(NUM_ENTRIES - 1)) ? '0 : cnt_idx + 1'b1;
				ring_wr.prev_we   = 1'b1;
				ring_wr.prev_addr = cnt_idx;
				ring_wr.prev_data = (cnt_idx == '0) ? IDX_W'(NUM_ENTRIES - 1) : cnt_idx - 1'b1;
				if (cnt_idx == IDX_W'(NUM_ENTRIES - 1)) begin
					state_d = S_IDLE;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_IDLE: begin
				ent_raddr = IDX_W'(s_tdata[55:48]);
				if (s_tvalid) begin
					kind_d  = kind_t'(s_tuser);
					dev_d   = s_tdata[15:0];
					blk_d   = s_tdata[47:16];
					eidx_d  = s_tdata[55:48];
					cnt_d   = '0;
					vld_d   = 1'b0;
					found_d = 1'b0;
					rwb_d   = '0;
					unique case (kind_t'(s_tuser))
						K_GET:          state_d = (s_tdata[15:0] != '0) ? S_HSCAN : S_RSCAN;
						K_REL, K_MARK:  state_d = S_UPD;
						K_INV:          state_d = S_INV;
						default:        state_d = S_IDLE;
					endcase
				end
			end
			S_HSCAN, S_INV: begin
				ent_raddr = cnt_idx;
				if (cnt_q != SCAN_W'(NUM_ENTRIES)) begin
					cnt_d = cnt_q + 1'b1;
					cur_d = cnt_idx;
					vld_d = 1'b1;
				end
				if (vld_q) begin
					if (state_q == S_HSCAN) begin
						if (ent_rdata.dev == dev_q && ent_rdata.blk == blk_q) begin
							ent_we = 1'b1;
							if (ent_rdata.cnt != '1) begin
								ent_wdata.cnt = ent_rdata.cnt + 1'b1;
							end
							rsts_d  = STS_HIT;
							rent_d  = ENTRY_W'(cur_q);
							rlk_d   = ent_rdata.lock;
							rvd_d   = ent_rdata.valid;
							state_d = S_DONE;
						end else if (cnt_q == SCAN_W'(NUM_ENTRIES)) begin
							state_d = S_RSCAN;
							vld_d   = 1'b0;
							cnt_d   = '0;
						end
					end else begin
						if (ent_rdata.dev == dev_q) begin
							ent_we          = 1'b1;
							ent_wdata.valid = 1'b0;
							ent_wdata.dirty = 1'b0;
						end
						if (cnt_q == SCAN_W'(NUM_ENTRIES)) begin
							rsts_d  = STS_INVAL;
							rent_d  = '0;
							rlk_d   = 1'b0;
							rvd_d   = 1'b0;
							state_d = S_DONE;
						end
					end
				end
			end
			S_RSCAN: begin
				if (!vld_q) begin
					ent_raddr  = head_q;
					ring_raddr = head_q;
					cur_d      = head_q;
					vld_d      = 1'b1;
					cnt_d      = '0;
				end else begin
					// walk along the ring: next address comes from the link just read
					ent_raddr  = ring_rnext;
					ring_raddr = ring_rnext;
					cur_d      = ring_rnext;
					cnt_d      = cnt_q + 1'b1;
					if (take) begin
						found_d = 1'b1;
						best_d  = cur_q;
						bbad_d  = bad;
						bent_d  = ent_rdata;
					end
					if ((take && bad == 2'd0) || cnt_q == SCAN_W'(NUM_ENTRIES - 1)) begin
						state_d = S_DECIDE;
					end
				end
			end
			S_DECIDE: begin
				ring_raddr = best_q;
				rent_d     = ENTRY_W'(best_q);
				rlk_d      = 1'b0;
				rvd_d      = 1'b0;
				state_d    = S_DONE;
				if (!found_q) begin
					rsts_d = STS_NONE;
					rent_d = '0;
				end else if (bent_q.lock) begin
					rsts_d = STS_LOCKED;
					rlk_d  = 1'b1;
					rvd_d  = bent_q.valid;
				end else if (bent_q.dirty) begin
					rsts_d = STS_DIRTY;
					rvd_d  = bent_q.valid;
					rwb_d  = bent_q.dev;
				end else begin
					rsts_d    = STS_ALLOC;
					ent_we    = 1'b1;
					ent_waddr = best_q;
					ent_wdata = '{dev: dev_q, blk: blk_q, cnt: CNT_W'(1),
						dirty: 1'b0, lock: 1'b0, valid: 1'b0};
					state_d   = S_MV1;
				end
			end
			S_MV1: begin
				// unlink the victim
				ring_wr.next_we   = 1'b1;
				ring_wr.next_addr = ring_rprev;
				ring_wr.next_data = ring_rnext;
				ring_wr.prev_we   = 1'b1;
				ring_wr.prev_addr = ring_rnext;
				ring_wr.prev_data = ring_rprev;
				if (head_q == best_q) begin
					head_d = ring_rnext;
				end
				state_d = S_MV2;
			end
			S_MV2: begin
				ring_raddr = head_q;
				state_d    = S_MV3;
			end
			S_MV3: begin
				ring_raddr        = head_q;
				t_d               = ring_rprev;
				ring_wr.next_we   = 1'b1;
				ring_wr.next_addr = best_q;
				ring_wr.next_data = head_q;
				ring_wr.prev_we   = 1'b1;
				ring_wr.prev_addr = best_q;
				ring_wr.prev_data = ring_rprev;
				state_d           = S_MV4;
			end
			S_MV4: begin
				ring_wr.next_we   = 1'b1;
				ring_wr.next_addr = t_q;
				ring_wr.next_data = best_q;
				ring_wr.prev_we   = 1'b1;
				ring_wr.prev_addr = head_q;
				ring_wr.prev_data = best_q;
				state_d           = S_DONE;
			end
			S_UPD: begin
				ent_waddr = IDX_W'(eidx_q);
				rent_d    = eidx_q;
				rlk_d     = 1'b0;
				rvd_d     = 1'b0;
				state_d   = S_DONE;
				if (kind_q == K_REL) begin
					rsts_d = STS_RELERR;
					if (in_range) begin
						rlk_d = ent_rdata.lock;
						rvd_d = ent_rdata.valid;
						if (ent_rdata.cnt != '0) begin
							rsts_d        = STS_REL;
							ent_we        = 1'b1;
							ent_wdata.cnt = ent_rdata.cnt - 1'b1;
						end
					end
				end else begin
					rsts_d = STS_MARKS;
					if (in_range) begin
						ent_we          = 1'b1;
						ent_wdata.lock  = set_lock_q;
						ent_wdata.dirty = set_dirty_q;
						ent_wdata.valid = set_valid_q;
						rlk_d           = set_lock_q;
						rvd_d           = set_valid_q;
					end
				end
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			set_lock_q  <= s_tdata[56];
			set_dirty_q <= s_tdata[57];
			set_valid_q <= s_tdata[58];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {6'b0, rwb_q, rvd_q, rlk_q, rent_q};
			m_tuser_q <= rsts_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`include "block_buffer_cache_allocator_assert.svh"

	`BBCA_ASSERT_NOW(a_wb_only_dirty, m_tvalid && m_tuser != STS_DIRTY, m_tdata[25:10] == '0)
	`BBCA_ASSERT_NOW(a_alloc_marks_clear, m_tvalid && m_tuser == STS_ALLOC, m_tdata[9:8] == 2'b00)
	`BBCA_ASSERT_NOW(a_ring_walk_bound, state_q == S_RSCAN, cnt_q < SCAN_W'(NUM_ENTRIES))
	`BBCA_ASSERT_NEXT(a_done_loads_out, state_q == S_DONE && (!m_tvalid_q || m_tready), m_tvalid)

endmodule
